// File: rtl/core/tssf_pkg.sv
// shared constants and types of the triangle span fill block
package tssf_pkg;

    localparam int TILE_ROWS = 64;
    localparam int X_RANGE   = 1024;
    localparam int FRAC_BITS = 16;

    localparam int XW = 10;
    localparam int YW = 6;
    localparam int SW = 12;
    localparam int CW = 7;
    localparam int EW = XW + FRAC_BITS + 3;
    localparam int DW = XW + FRAC_BITS;
    localparam int TW = EW - FRAC_BITS;

    localparam int SPAN_LIMIT = (TILE_ROWS < 64) ? TILE_ROWS : 64;
    localparam logic [XW-1:0] XMASK = XW'(X_RANGE - 1);
    localparam logic signed [EW-1:0] HALF_FX = EW'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [YW-1:0]        row;
        logic [CW-1:0]        cnt;
        logic                 down;
        logic                 raw;
        logic                 last;
        logic signed [EW-1:0] l0;
        logic signed [EW-1:0] r0;
        logic signed [EW-1:0] sl;
        logic signed [EW-1:0] sr;
    } t_piece;

    typedef struct packed {
        logic [YW-1:0]        row;
        logic signed [SW-1:0] span_start;
        logic signed [SW-1:0] span_end;
        logic                 last;
    } t_span;

endpackage

// File: rtl/core/tssf_div.sv
// iterative restoring divider, one quotient bit per cycle
module tssf_div #(
    parameter int DW = 26,
    parameter int VW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int NW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_dv, n_dv;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dv};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dv   = r_dv;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(DW);
            n_rem  = '0;
            n_dv   = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? VW'(trial - {1'b0, r_dv}) : trial[VW-1:0];
            n_quo = {r_quo[DW-2:0], fits};
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dv  <= n_dv;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// File: rtl/core/tssf_fifo.sv
// small register queue with show-ahead read
module tssf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// File: rtl/core/tssf_front.sv
// front end: accept, sort, classify, and set up each edge walk piece
module tssf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [9:0]             i_first_x,
    input  logic [5:0]             i_first_y,
    input  logic [9:0]             i_second_x,
    input  logic [5:0]             i_second_y,
    input  logic [9:0]             i_third_x,
    input  logic [5:0]             i_third_y,
    output logic                   o_cmd_push,
    output tssf_pkg::t_piece       o_cmd,
    input  logic                   i_cmd_full
);
    import tssf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_MDIV = 7'b0000100,
        S_SET  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_PUSH = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        K_FLAT = 2'd0,
        K_FB   = 2'd1,
        K_FT   = 2'd2,
        K_GEN  = 2'd3
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind;
    logic   r_stage;
    logic   r_dstart, n_dstart;

    logic [XW-1:0] r_vx [3];
    logic [YW-1:0] r_vy [3];
    logic [XW-1:0] r_mx;
    logic [16:0]   r_num;

    logic [XW-1:0]       r_apx;
    logic [YW-1:0]       r_row;
    logic [CW-1:0]       r_cnt;
    logic                r_down;
    logic signed [XW:0]  r_dx1, r_dx2;
    logic [YW-1:0]       r_dy;
    logic signed [EW-1:0] r_q1, r_q2;

    // input masking, rejection and sorting by (y, x)
    logic [XW-1:0] mx0, mx1, mx2;
    logic          reject, accept;
    logic [15:0]   k0, k1, k2, a1, b1, b2, c0, c1;
    logic [15:0]   s0, s1, s2;

    assign mx0 = i_first_x & XMASK;
    assign mx1 = i_second_x & XMASK;
    assign mx2 = i_third_x & XMASK;
    assign reject = (mx0 == '0) || (mx1 == '0) || (mx2 == '0) ||
                    (i_first_y == '0) || (i_second_y == '0) || (i_third_y == '0);
    assign full   = r_state != S_IDLE;
    assign accept = push && !full;

    assign k0 = {i_first_y, mx0};
    assign k1 = {i_second_y, mx1};
    assign k2 = {i_third_y, mx2};
    assign c0 = (k1 < k0) ? k1 : k0;
    assign a1 = (k1 < k0) ? k0 : k1;
    assign b1 = (k2 < a1) ? k2 : a1;
    assign b2 = (k2 < a1) ? a1 : k2;
    assign s0 = (b1 < c0) ? b1 : c0;
    assign c1 = (b1 < c0) ? c0 : b1;
    assign s1 = c1;
    assign s2 = b2;

    // split point numerator
    logic [YW-1:0]        dd, dy01;
    logic [15:0]          p1;
    logic signed [XW:0]   dx20;
    logic signed [16:0]   p2;
    logic signed [17:0]   num;

    assign dd   = r_vy[2] - r_vy[0];
    assign dy01 = r_vy[1] - r_vy[0];
    assign dx20 = $signed({1'b0, r_vx[2]}) - $signed({1'b0, r_vx[0]});
    assign p1   = r_vx[0] * dd;
    assign p2   = $signed({1'b0, dy01}) * dx20;
    assign num  = $signed({2'b0, p1}) + $signed({p2[16], p2});

    // piece geometry
    logic [XW-1:0] ax, bx, cx;
    logic [YW-1:0] ay, by, cy;
    logic          ft;
    logic [XW-1:0] g_apx;
    logic [YW-1:0] g_row, g_dy;
    logic [CW-1:0] g_cnt;
    logic signed [XW:0] g_dx1, g_dx2;

    always_comb begin
        ax = r_vx[0]; ay = r_vy[0];
        bx = r_vx[1]; by = r_vy[1];
        cx = r_vx[2]; cy = r_vy[2];
        ft = (r_kind == K_FT);
        if (r_kind == K_GEN && !r_stage) begin
            cx = r_mx; cy = r_vy[1];
        end else if (r_kind == K_GEN) begin
            ax = r_vx[1]; ay = r_vy[1];
            bx = r_mx;    by = r_vy[1];
            ft = 1'b1;
        end
        if (ft) begin
            g_apx = cx;
            g_row = cy;
            g_dy  = cy - ay;
            g_cnt = CW'(cy - ay);
            g_dx1 = $signed({1'b0, cx}) - $signed({1'b0, ax});
            g_dx2 = $signed({1'b0, cx}) - $signed({1'b0, bx});
        end else begin
            g_apx = ax;
            g_row = ay;
            g_dy  = by - ay;
            g_cnt = CW'(by - ay) + CW'(1);
            g_dx1 = $signed({1'b0, bx}) - $signed({1'b0, ax});
            g_dx2 = $signed({1'b0, cx}) - $signed({1'b0, ax});
        end
    end

    // shared divider operands
    logic          div_done;
    logic [DW-1:0] div_q, div_dvd;
    logic [YW-1:0] div_dvs;
    logic signed [XW:0] dsel;
    logic [XW:0]        dabs;
    logic signed [EW-1:0] qext, qsgn;

    assign dsel    = (r_state == S_DIV2) ? r_dx2 : r_dx1;
    assign dabs    = dsel[XW] ? 11'(-dsel) : 11'(dsel);
    assign div_dvd = (r_state == S_MDIV) ? DW'(r_num) : {dabs[XW-1:0], {FRAC_BITS{1'b0}}};
    assign div_dvs = (r_state == S_MDIV) ? dd : r_dy;
    assign qext    = $signed({3'b0, div_q});
    assign qsgn    = dsel[XW] ? -qext : qext;

    tssf_div #(.DW(DW), .VW(YW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        n_state  = r_state;
        n_dstart = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && !reject) begin
                    n_state = (s0[15:10] != s1[15:10] && s1[15:10] != s2[15:10]) ?
                              S_MUL : S_SET;
                end
            end
            S_MUL: begin
                n_state  = S_MDIV;
                n_dstart = 1'b1;
            end
            S_MDIV: begin
                if (div_done) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                if (r_kind == K_FLAT) begin
                    n_state = S_PUSH;
                end else begin
                    n_state  = S_DIV1;
                    n_dstart = 1'b1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    n_state  = S_DIV2;
                    n_dstart = 1'b1;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_cmd_full) begin
                    n_state = (r_kind == K_GEN && !r_stage) ? S_SET : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
            r_stage  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= n_dstart;
            if (r_state == S_IDLE) begin
                r_stage <= 1'b0;
            end else if (r_state == S_PUSH && !i_cmd_full) begin
                r_stage <= 1'b1;
            end
        end
        if (accept) begin
            r_vx[0] <= s0[9:0]; r_vy[0] <= s0[15:10];
            r_vx[1] <= s1[9:0]; r_vy[1] <= s1[15:10];
            r_vx[2] <= s2[9:0]; r_vy[2] <= s2[15:10];
            if (s1[15:10] == s2[15:10]) begin
                r_kind <= (s0[15:10] == s1[15:10]) ? K_FLAT : K_FB;
            end else if (s0[15:10] == s1[15:10]) begin
                r_kind <= K_FT;
            end else begin
                r_kind <= K_GEN;
            end
        end
        if (r_state == S_MUL) begin
            r_num <= num[16:0];
        end
        if (r_state == S_MDIV && div_done) begin
            r_mx <= div_q[XW-1:0];
        end
        if (r_state == S_SET) begin
            r_apx  <= g_apx;
            r_row  <= g_row;
            r_cnt  <= g_cnt;
            r_down <= ft;
            r_dx1  <= g_dx1;
            r_dx2  <= g_dx2;
            r_dy   <= g_dy;
            r_q1   <= '0;
            r_q2   <= '0;
        end
        if (r_state == S_DIV1 && div_done) begin
            r_q1 <= qsgn;
        end
        if (r_state == S_DIV2 && div_done) begin
            r_q2 <= qsgn;
        end
    end

    // left edge takes the smaller step walking down the tile, the larger walking up
    logic q1_lt;
    assign q1_lt = r_q1 < r_q2;

    always_comb begin
        o_cmd      = '0;
        o_cmd.row  = (r_kind == K_FLAT) ? r_vy[0] : r_row;
        o_cmd.cnt  = (r_kind == K_FLAT) ? CW'(1) : r_cnt;
        o_cmd.down = r_down;
        o_cmd.raw  = (r_kind == K_FLAT);
        o_cmd.last = !(r_kind == K_GEN && !r_stage);
        if (r_kind == K_FLAT) begin
            o_cmd.l0 = $signed({3'b0, r_vx[0], {FRAC_BITS{1'b0}}});
            o_cmd.r0 = $signed({3'b0, r_vx[2], {FRAC_BITS{1'b0}}});
        end else begin
            o_cmd.l0 = $signed({3'b0, r_apx, {FRAC_BITS{1'b0}}});
            o_cmd.r0 = $signed({3'b0, r_apx, {FRAC_BITS{1'b0}}});
        end
        if (q1_lt != r_down) begin
            o_cmd.sl = r_q1;
            o_cmd.sr = r_q2;
        end else begin
            o_cmd.sl = r_q2;
            o_cmd.sr = r_q1;
        end
    end

    assign o_cmd_push = (r_state == S_PUSH) && !i_cmd_full;
endmodule

// File: rtl/core/tssf_back.sv
// back end: walks one piece a row per cycle while the span queue has room, and forms the spans
module tssf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tssf_pkg::t_piece i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output logic             o_span_push,
    output tssf_pkg::t_span  o_span,
    input  logic             i_span_full
);
    import tssf_pkg::*;

    logic                 r_active;
    t_piece               r_p;
    logic signed [EW-1:0] r_l, r_r;
    logic [YW-1:0]        r_rowc;
    logic [CW-1:0]        r_left;
    logic [CW-1:0]        r_tri;

    logic load, step, keep;
    assign load = !r_active && !i_cmd_empty;
    assign step = r_active && !i_span_full;
    assign keep = r_tri < CW'(SPAN_LIMIT);
    assign o_cmd_pop   = load;
    assign o_span_push = step && keep;

    // truncation toward zero of edge minus and plus one half; raw pieces take the integer part of the edges
    logic signed [EW-1:0] lm, rp;
    logic [EW-1:0]        lmag, rmag;
    logic signed [TW-1:0] lt, rt, st, et;

    assign lm   = r_l - HALF_FX;
    assign rp   = r_r + HALF_FX;
    assign lmag = lm[EW-1] ? EW'(-lm) : EW'(lm);
    assign rmag = rp[EW-1] ? EW'(-rp) : EW'(rp);

    always_comb begin
        if (r_p.raw) begin
            lt = r_l[EW-1:FRAC_BITS];
            rt = r_r[EW-1:FRAC_BITS];
        end else begin
            lt = lm[EW-1] ? -$signed(lmag[EW-1:FRAC_BITS]) : $signed(lmag[EW-1:FRAC_BITS]);
            rt = rp[EW-1] ? -$signed(rmag[EW-1:FRAC_BITS]) : $signed(rmag[EW-1:FRAC_BITS]);
        end
        st = (lt > rt) ? rt : lt;
        et = (lt > rt) ? lt : rt;
    end

    always_comb begin
        o_span.row        = r_rowc;
        o_span.span_start = st[SW-1:0];
        o_span.span_end   = et[SW-1:0];
        o_span.last       = (r_p.last && r_left == CW'(1)) ||
                            (r_tri == CW'(SPAN_LIMIT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tri    <= '0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (step) begin
                if (r_left == CW'(1)) begin
                    r_active <= 1'b0;
                end
                if (r_left == CW'(1) && r_p.last) begin
                    r_tri <= '0;
                end else if (keep) begin
                    r_tri <= r_tri + CW'(1);
                end
            end
        end
        if (load) begin
            r_p    <= i_cmd;
            r_l    <= i_cmd.l0;
            r_r    <= i_cmd.r0;
            r_rowc <= i_cmd.row;
            r_left <= i_cmd.cnt;
        end else if (step) begin
            r_left <= r_left - CW'(1);
            if (r_p.down) begin
                r_rowc <= r_rowc - YW'(1);
                r_l    <= r_l - r_p.sl;
                r_r    <= r_r - r_p.sr;
            end else begin
                r_rowc <= r_rowc + YW'(1);
                r_l    <= r_l + r_p.sl;
                r_r    <= r_r + r_p.sr;
            end
        end
    end
endmodule

// File: rtl/core/triangle_scanline_span_fill.sv
// top level of the triangle scanline span fill block
// usage
//   input side is a queue: drive the three vertices and raise push; the item
//   is taken at a clock edge where push is high and full is low
//   result side is a queue: while empty is low the oldest span sits on
//   o_row, o_span_start, o_span_end, o_last_span; pop takes it
//   each triangle yields its spans top piece first, o_last_span marks the end;
//   a triangle with any zero coordinate yields no span at all
// timing
//   the front sorts and classifies at accept, then runs a shared restoring
//   divider, one quotient bit per cycle, for the quotients it needs: none for
//   a single-row triangle, two for flat bottom or flat top, five for a split
//   one; full stays high until the last piece of the triangle is pushed
//   the back walks one span per cycle while the span queue has room
//   a four-entry piece queue lets the front set up the next triangle while
//   the back still walks the last one
// stalls and reset
//   holding pop low fills the span queue, the back then waits, the piece
//   queue fills and full stays high; no span is lost
//   synchronous active-low reset empties both queues and idles both ends
module triangle_scanline_span_fill (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [9:0]         i_first_x,
    input  logic [5:0]         i_first_y,
    input  logic [9:0]         i_second_x,
    input  logic [5:0]         i_second_y,
    input  logic [9:0]         i_third_x,
    input  logic [5:0]         i_third_y,
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         o_row,
    output logic signed [11:0] o_span_start,
    output logic signed [11:0] o_span_end,
    output logic               o_last_span
);
    import tssf_pkg::*;

    // front to piece queue
    logic   cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_piece cmd_in, cmd_out;

    // back to span queue
    logic   span_push, span_full;
    t_span  span_in, span_out;

    tssf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // piece queue decouples divider setup from the walk
    tssf_fifo #(.W($bits(t_piece)), .DEPTH(4)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    tssf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_span_push (span_push),
        .o_span      (span_in),
        .i_span_full (span_full)
    );

    // span queue parts the walk from the consumer
    tssf_fifo #(.W($bits(t_span)), .DEPTH(4)) u_spanq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (span_push),
        .i_data  (span_in),
        .o_full  (span_full),
        .i_pop   (pop),
        .o_data  (span_out),
        .o_empty (empty)
    );

    assign o_row        = span_out.row;
    assign o_span_start = span_out.span_start;
    assign o_span_end   = span_out.span_end;
    assign o_last_span  = span_out.last;
endmodule

// File: tb/triangle_scanline_span_fill_checker.sv
// span checker: predicts the spans of each accepted triangle and compares them
`timescale 1ns / 100ps
module triangle_scanline_span_fill_checker
    import tssf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [9:0]         i_first_x,
    input  logic [5:0]         i_first_y,
    input  logic [9:0]         i_second_x,
    input  logic [5:0]         i_second_y,
    input  logic [9:0]         i_third_x,
    input  logic [5:0]         i_third_y,
    input  logic               empty,
    input  logic               pop,
    input  logic [5:0]         o_row,
    input  logic signed [11:0] o_span_start,
    input  logic signed [11:0] o_span_end,
    input  logic               o_last_span,
    output int                 o_errors,
    output int                 o_spans_pending
);

    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = longint'(1) << (FRAC_BITS - 1);

    t_span spans_due[$];
    int    tri_spans;
    int    err_cnt = 0;
    int    pend_cnt = 0;

    function automatic longint trunc_q(longint v);
        if (v >= 0) return v >>> FRAC_BITS;
        return -((-v) >>> FRAC_BITS);
    endfunction

    function automatic longint edge_slope(longint dx, longint dy);
        longint mag;
        mag = ((dx < 0 ? -dx : dx) * ONE_Q) / dy;
        return dx < 0 ? -mag : mag;
    endfunction

    function automatic void add_span(longint row, longint a, longint b);
        t_span s;
        longint t;
        if (tri_spans >= SPAN_LIMIT) return;
        if (a > b) begin
            t = a; a = b; b = t;
        end
        s.row = row[5:0];
        s.span_start = a[11:0];
        s.span_end = b[11:0];
        s.last = 1'b0;
        spans_due.push_back(s);
        tri_spans++;
    endfunction

    function automatic void walk_down(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        longint d, s0, s1, l, r, t;
        if (by == ay || cy == ay) begin
            add_span(ay, ax, cx);
            return;
        end
        d = by - ay;
        s0 = edge_slope(bx - ax, d);
        s1 = edge_slope(cx - ax, d);
        if (s0 > s1) begin
            t = s0; s0 = s1; s1 = t;
        end
        l = ax * ONE_Q;
        r = l;
        for (longint y = ay; y <= by; y++) begin
            add_span(y, trunc_q(l - HALF_Q), trunc_q(r + HALF_Q));
            l += s0;
            r += s1;
        end
    endfunction

    function automatic void walk_up(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
        longint s0, s1, l, r, t;
        if (cy == ay || cy == by) begin
            add_span(ay, ax, cx);
            return;
        end
        s0 = edge_slope(cx - ax, cy - ay);
        s1 = edge_slope(cx - bx, cy - by);
        if (s1 > s0) begin
            t = s0; s0 = s1; s1 = t;
        end
        l = cx * ONE_Q;
        r = l;
        for (longint y = cy; y > ay; y--) begin
            add_span(y, trunc_q(l - HALF_Q), trunc_q(r + HALF_Q));
            l -= s0;
            r -= s1;
        end
    endfunction

    function automatic bit vtx_less(longint px, longint py, longint qx, longint qy);
        if (py != qy) return py < qy;
        return px < qx;
    endfunction

    function automatic void predict_spans(longint x0, longint y0, longint x1, longint y1,
                                          longint x2, longint y2);
        longint vx[3], vy[3], t, dd, num, mx;
        vx = '{x0, x1, x2};
        vy = '{y0, y1, y2};
        tri_spans = 0;
        // any zero coordinate drops the triangle
        for (int i = 0; i < 3; i++)
            if (vx[i] == 0 || vy[i] == 0) return;
        // three-step sort by y then x
        for (int k = 0; k < 3; k++) begin
            int j;
            j = (k == 1) ? 1 : 0;
            if (vtx_less(vx[j+1], vy[j+1], vx[j], vy[j])) begin
                t = vx[j]; vx[j] = vx[j+1]; vx[j+1] = t;
                t = vy[j]; vy[j] = vy[j+1]; vy[j+1] = t;
            end
        end
        if (vy[1] == vy[2])
            walk_down(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        else if (vy[0] == vy[1])
            walk_up(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        else begin
            // split at the middle row, split x is exact floor of the edge point
            dd = vy[2] - vy[0];
            num = vx[0] * dd + (vy[1] - vy[0]) * (vx[2] - vx[0]);
            mx = num / dd;
            walk_down(vx[0], vy[0], vx[1], vy[1], mx, vy[1]);
            walk_up(vx[1], vy[1], mx, vy[1], vx[2], vy[2]);
        end
        if (tri_spans > 0) spans_due[spans_due.size()-1].last = 1'b1;
    endfunction

    assign o_errors = err_cnt;
    assign o_spans_pending = pend_cnt;

    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (spans_due.size() == 0) begin
                    $display("%0t: span with none expected: row %0d start %0d end %0d last %0b",
                             $time, o_row, o_span_start, o_span_end, o_last_span);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = spans_due[0];
                    spans_due.delete(0);
                    if (want.row !== o_row || want.span_start !== o_span_start ||
                        want.span_end !== o_span_end || want.last !== o_last_span) begin
                        $display("%0t: mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $time, want.row, want.span_start, want.span_end, want.last,
                                 o_row, o_span_start, o_span_end, o_last_span);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            if (push && !full)
                predict_spans(i_first_x, i_first_y, i_second_x, i_second_y,
                              i_third_x, i_third_y);
        end
        pend_cnt = spans_due.size();
    end

endmodule

// File: tb/triangle_scanline_span_fill_tb.sv
// testbench top: triangle stimulus, clock, reset and verdict
`timescale 1ns / 100ps
module triangle_scanline_span_fill_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic [9:0]         i_first_x = '0, i_second_x = '0, i_third_x = '0;
    logic [5:0]         i_first_y = '0, i_second_y = '0, i_third_y = '0;
    logic               full, empty, o_last_span;
    logic [5:0]         o_row;
    logic signed [11:0] o_span_start, o_span_end;
    int                 errors, spans_pending;

    // idle percentages of each side, changed per phase
    int send_idle_pct = 18;
    int recv_idle_pct = 87;

    always #5 i_clk = ~i_clk;

    triangle_scanline_span_fill dut (.*);

    triangle_scanline_span_fill_checker checker_i (
        .i_clk, .i_rst_n, .push, .full,
        .i_first_x, .i_first_y, .i_second_x, .i_second_y, .i_third_x, .i_third_y,
        .empty, .pop, .o_row, .o_span_start, .o_span_end, .o_last_span,
        .o_errors(errors), .o_spans_pending(spans_pending)
    );

    // receiver: random pop stalls
    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one triangle: hold it until taken, then maybe idle a while
    task automatic send_tri(input logic [9:0] x0, input logic [5:0] y0,
                            input logic [9:0] x1, input logic [5:0] y1,
                            input logic [9:0] x2, input logic [5:0] y2);
        push <= 1'b1;
        i_first_x <= x0; i_first_y <= y0;
        i_second_x <= x1; i_second_y <= y1;
        i_third_x <= x2; i_third_y <= y2;
        do @(posedge i_clk); while (full);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // wait until the checker has seen every expected span, resume on a rising edge
    task automatic wait_drained();
        @(negedge i_clk);
        while (spans_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [9:0] x[3];
        logic [5:0] y[3];
        int base, h;
        // mostly well-formed, short triangles usually, a few tall ones
        h = ($urandom_range(0, 9) == 0) ? 62 : int'($urandom_range(0, 12));
        base = int'($urandom_range(1, 63 - h));
        for (int i = 0; i < 3; i++) begin
            x[i] = 10'($urandom_range(1, 1023));
            y[i] = 6'($urandom_range(base, base + h));
        end
        case ($urandom_range(0, 9))
            0: x[$urandom_range(0, 2)] = 10'($urandom_range(0, 1023)) & 10'h3f0;
            1: y[$urandom_range(0, 2)] = 6'd0;
            2: y[1] = y[2];
            3: y[0] = y[1];
            4: begin
                x[0] = 10'($urandom); x[1] = 10'($urandom); x[2] = 10'($urandom);
                y[0] = 6'($urandom); y[1] = 6'($urandom); y[2] = 6'($urandom);
            end
            default: ;
        endcase
        send_tri(x[0], y[0], x[1], y[1], x[2], y[2]);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero coordinates give nothing
        send_tri(10'd0, 6'd5, 10'd20, 6'd9, 10'd30, 6'd12);
        send_tri(10'd5, 6'd0, 10'd20, 6'd9, 10'd30, 6'd12);
        send_tri(10'd5, 6'd4, 10'd20, 6'd9, 10'd30, 6'd0);
        // all vertices on one row
        send_tri(10'd700, 6'd20, 10'd3, 6'd20, 10'd1023, 6'd20);
        send_tri(10'd1, 6'd63, 10'd1, 6'd63, 10'd1, 6'd63);
        // flat bottom, flat top, general
        send_tri(10'd100, 6'd2, 10'd40, 6'd12, 10'd200, 6'd12);
        send_tri(10'd40, 6'd5, 10'd300, 6'd5, 10'd120, 6'd30);
        send_tri(10'd500, 6'd1, 10'd20, 6'd30, 10'd900, 6'd63);
        // extremes and tallest possible
        send_tri(10'd1023, 6'd1, 10'd1, 6'd63, 10'd1023, 6'd63);
        send_tri(10'd1, 6'd1, 10'd1023, 6'd1, 10'd512, 6'd63);
        send_tri(10'd1, 6'd1, 10'd1023, 6'd32, 10'd1, 6'd63);
        send_tri(10'd1023, 6'd63, 10'd1, 6'd1, 10'd1023, 6'd2);
        send_tri(10'd1, 6'd62, 10'd1023, 6'd63, 10'd2, 6'd1);
        send_tri(10'd682, 6'd21, 10'd341, 6'd42, 10'd1023, 6'd63);
        // degenerate: repeated vertex, vertical edge
        send_tri(10'd50, 6'd10, 10'd50, 6'd10, 10'd90, 6'd20);
        send_tri(10'd77, 6'd3, 10'd77, 6'd40, 10'd77, 6'd22);

        for (int n = 0; n < 350; n++) begin
            if (n == 120) begin
                send_idle_pct = 87;
                recv_idle_pct = 18;
            end else if (n == 240) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 200) begin
                // let the block drain completely before going on
                push <= 1'b0;
                wait_drained();
            end
            send_random();
        end
        push <= 1'b0;
        recv_idle_pct = 0;

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && spans_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
